@@ design/csq_pkg.sv @@
// csq_pkg: shared sizes, operation and status codes, and the control/status
// structs between the semaphore controller and datapath. No dependencies.
package csq_pkg;

  localparam int QUEUE_DEPTH     = 16;
  localparam int THREAD_ID_WIDTH = 8;
  localparam int COUNT_WIDTH     = 16;

  localparam int QADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  // compare width for the open value against the count maximum
  localparam int INIT_CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    MODE_OPEN   = 2'd0,
    MODE_WAIT   = 2'd1,
    MODE_SIGNAL = 2'd2,
    MODE_CLOSE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BLOCKED = 3'd1,
    ST_WOKEN   = 3'd2,
    ST_CLOSED  = 3'd3,
    ST_FULL    = 3'd4,
    ST_SAT     = 3'd5,
    ST_NONE    = 3'd6
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic latch;  // capture the incoming operation
    logic load;   // commit one step and load the result register
  } ctl_cmd_t;

  typedef struct packed {
    logic more;   // close still has waiters after this step
  } dp_sts_t;

endpackage

@@ design/csq_ram.sv @@
// csq_ram: generic single-write, single-read RAM with registered read data.
// Self-contained, no package dependency.
module csq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/csq_ctrl.sv @@
// csq_ctrl: two-state controller; owns the input handshake and the result
// valid flag. Depends on csq_pkg for the state type and command structs.
module csq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  csq_pkg::dp_sts_t  sts,
  output csq_pkg::ctl_cmd_t cmd
);
  import csq_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // result register can take a new beat
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free && !sts.more) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.latch = 1'b0;
    cmd.load  = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      S_EXEC: begin
        cmd.load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/csq_dp.sv @@
// csq_dp: semaphore count, closed mark, wait queue pointers and result
// registers; the queue itself lives in a csq_ram. Depends on csq_pkg, csq_ram.
module csq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  csq_pkg::ctl_cmd_t cmd,
  output csq_pkg::dp_sts_t  sts,
  input  logic [1:0]        in_mode,
  input  logic [7:0]        in_thread_id,
  input  logic [15:0]       in_init_value,
  output logic [2:0]        out_status,
  output logic [7:0]        out_woken_thread,
  output logic              out_wake_error,
  output logic [15:0]       out_count_now,
  output logic              out_last
);
  import csq_pkg::*;

  // captured operation
  mode_t                      mode_r;
  logic [THREAD_ID_WIDTH-1:0] tid_r;
  logic [15:0]                init_r;

  // semaphore state
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   closed_r, closed_nxt;
  logic [QADDR_W-1:0]     head_r, head_nxt;
  logic [QADDR_W-1:0]     tail_r, tail_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;

  // result registers
  logic [2:0]  status_r;
  logic [7:0]  woken_r;
  logic        err_r;
  logic [15:0] cnt_out_r;
  logic        last_r;

  logic [THREAD_ID_WIDTH+7:0] tid_ext;
  logic [THREAD_ID_WIDTH-1:0] rd_tid;
  logic [THREAD_ID_WIDTH+7:0] rd_ext;
  logic [INIT_CMP_W-1:0]      init_cmp;
  logic [COUNT_WIDTH+15:0]    cnt_ext;
  logic [COUNT_WIDTH-1:0]     open_count;

  status_t                    res_status;
  logic [THREAD_ID_WIDTH-1:0] res_tid;
  logic                       res_err;
  logic                       res_last;
  logic                       enq, deq;
  logic [COUNT_WIDTH-1:0]     step_count;
  logic                       step_closed;
  logic                       step_reset_q;

  assign tid_ext = {{THREAD_ID_WIDTH{1'b0}}, in_thread_id};

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= mode_t'(in_mode);
      tid_r  <= tid_ext[THREAD_ID_WIDTH-1:0];
      init_r <= in_init_value;
    end
  end

  // open value saturates at the count maximum
  assign init_cmp = INIT_CMP_W'(init_r);
  always_comb begin
    if (init_cmp > INIT_CMP_W'(COUNT_MAX)) begin
      open_count = COUNT_MAX;
    end else begin
      open_count = init_cmp[COUNT_WIDTH-1:0];
    end
  end

  always_comb begin
    res_status   = ST_OK;
    res_tid      = '0;
    res_err      = 1'b0;
    res_last     = 1'b1;
    enq          = 1'b0;
    deq          = 1'b0;
    step_count   = count_r;
    step_closed  = closed_r;
    step_reset_q = 1'b0;
    case (mode_r)
      MODE_OPEN: begin
        step_count   = open_count;
        step_closed  = 1'b0;
        step_reset_q = 1'b1;
      end
      MODE_WAIT: begin
        if (closed_r) begin
          res_status = ST_CLOSED;
        end else if (count_r != '0) begin
          step_count = count_r - COUNT_WIDTH'(1);
        end else if (fill_r == FILL_W'(QUEUE_DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          enq        = 1'b1;
          res_status = ST_BLOCKED;
        end
      end
      MODE_SIGNAL: begin
        if (closed_r) begin
          res_status = ST_CLOSED;
        end else if (fill_r != '0) begin
          deq        = 1'b1;
          res_status = ST_WOKEN;
          res_tid    = rd_tid;
        end else if (count_r == COUNT_MAX) begin
          res_status = ST_SAT;
        end else begin
          step_count = count_r + COUNT_WIDTH'(1);
        end
      end
      MODE_CLOSE: begin
        step_closed = 1'b1;
        if (fill_r == '0) begin
          res_status = ST_NONE;
        end else begin
          deq        = 1'b1;
          res_status = ST_WOKEN;
          res_tid    = rd_tid;
          res_err    = 1'b1;
          res_last   = (fill_r == FILL_W'(1));
        end
      end
      default: res_status = ST_OK;
    endcase
  end

  assign sts.more = (mode_r == MODE_CLOSE) && (fill_r > FILL_W'(1));

  always_comb begin
    count_nxt  = count_r;
    closed_nxt = closed_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    if (cmd.load) begin
      count_nxt  = step_count;
      closed_nxt = step_closed;
      if (step_reset_q) begin
        head_nxt = '0;
        tail_nxt = '0;
        fill_nxt = '0;
      end else if (enq) begin
        tail_nxt = (tail_r == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + QADDR_W'(1);
        fill_nxt = fill_r + FILL_W'(1);
      end else if (deq) begin
        head_nxt = (head_r == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + QADDR_W'(1);
        fill_nxt = fill_r - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      closed_r <= 1'b1;
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
    end else begin
      count_r  <= count_nxt;
      closed_r <= closed_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // read at the next head so the registered RAM output already holds the oldest waiter
  csq_ram #(
    .WIDTH (THREAD_ID_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (cmd.load && enq),
    .wr_addr (tail_r),
    .wr_data (tid_r),
    .rd_addr (head_nxt),
    .rd_data (rd_tid)
  );

  assign rd_ext  = {8'b0, res_tid};
  assign cnt_ext = {16'b0, step_count};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r  <= res_status;
      woken_r   <= rd_ext[7:0];
      err_r     <= res_err;
      cnt_out_r <= cnt_ext[15:0];
      last_r    <= res_last;
    end
  end

  assign out_status       = status_r;
  assign out_woken_thread = woken_r;
  assign out_wake_error   = err_r;
  assign out_count_now    = cnt_out_r;
  assign out_last         = last_r;

endmodule

@@ design/counting_semaphore_wait_queue_unit.sv @@
// counting_semaphore_wait_queue_unit: top level of the counting semaphore.
// Depends on csq_pkg, csq_ctrl, csq_dp (and csq_ram through csq_dp).
//
// Counting semaphore with a FIFO of blocked thread ids. Each input beat is
// one operation (open, wait, signal, close) and gives one result beat,
// except close, which gives one woken beat per queued waiter (oldest first,
// wake_error set) and out_last on the final one. An operation first
// captures the beat and reads the queue head from the queue RAM, then
// updates the state and loads the result register; a close with waiters
// drains one waiter per cycle while the output is not stalled. A new beat
// is taken while the previous result still waits in the output register.
// The state comes out of reset closed.
module counting_semaphore_wait_queue_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_thread_id,
  input  logic [15:0] in_init_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_woken_thread,
  output logic        out_wake_error,
  output logic [15:0] out_count_now,
  output logic        out_last
);
  import csq_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  csq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  csq_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_thread_id     (in_thread_id),
    .in_init_value    (in_init_value),
    .out_status       (out_status),
    .out_woken_thread (out_woken_thread),
    .out_wake_error   (out_wake_error),
    .out_count_now    (out_count_now),
    .out_last         (out_last)
  );

endmodule

@@ design/csq_checker.sv @@
// csq_checker: port-level checks on the semaphore top level, attached by
// bind. Depends on csq_pkg for the status codes.
module csq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_mode,
  input logic [7:0]  in_thread_id,
  input logic [15:0] in_init_value,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [7:0]  out_woken_thread,
  input logic        out_wake_error,
  input logic [15:0] out_count_now,
  input logic        out_last
);
  import csq_pkg::*;

  // one operation at a time: busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous operation in flight");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // only close drains several beats, all of them woken with error
  a_not_last_is_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_WOKEN && out_wake_error)
    else $error("non-final beat is not a close wakeup");

  a_err_only_woken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake_error |-> out_status == ST_WOKEN)
    else $error("wake error on a non-woken result");

endmodule

bind counting_semaphore_wait_queue_unit csq_checker u_csq_checker (.*);
